// ===== design/ajrf_pkg.sv =====
// Shared types, codes and widths of the angle jump rejection filter.
package ajrf_pkg;

    localparam int ANGLE_W = 32;
    localparam int TOKEN_W = 32;
    localparam int COUNT_W = 32;
    localparam int LIMIT_W = 31;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = LIMIT_W;
    localparam int TURN_W = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_JUMP_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_MODE = 1'd1;

    localparam logic [LIMIT_W-1:0] JUMP_LIMIT_RESET = 31'd4096;
    localparam logic WRAP_MODE_RESET = 1'b1;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_RESET  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_INIT      = 3'd3,
        ST_FAILED    = 3'd4,
        ST_RESET     = 3'd5
    } status_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [ANGLE_W-1:0]  sample_angle;
        logic                       sample_valid;
        logic [TOKEN_W-1:0]         frame_token;
    } req_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0]  out_angle;
        status_t                    status;
        logic [COUNT_W-1:0]         reject_total;
    } rsp_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] jump_limit;
        logic               wrap_mode;
    } cfg_t;

endpackage

// ===== design/ajrf_cfg.sv =====
// Configuration registers of the angle jump rejection filter.
module ajrf_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ajrf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ajrf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ajrf_pkg::cfg_t                 cfg
);
    import ajrf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_JUMP_LIMIT: cfg_next.jump_limit = cfg_data[LIMIT_W-1:0];
                CFG_WRAP_MODE:  cfg_next.wrap_mode = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jump_limit <= JUMP_LIMIT_RESET;
            cfg_reg.wrap_mode <= WRAP_MODE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/ajrf_filter.sv =====
// Filter state and the decision logic that turns one request into one response.
module ajrf_filter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  ajrf_pkg::req_t req,
    input  ajrf_pkg::cfg_t cfg,
    output ajrf_pkg::rsp_t rsp
);
    import ajrf_pkg::*;

    logic                      has_value_reg;
    logic                      has_value_next;
    logic signed [ANGLE_W-1:0] held_angle_reg;
    logic signed [ANGLE_W-1:0] held_angle_next;
    logic [TOKEN_W-1:0]        last_token_reg;
    logic [TOKEN_W-1:0]        last_token_next;
    logic [COUNT_W-1:0]        reject_count_reg;
    logic [COUNT_W-1:0]        reject_count_next;

    logic signed [ANGLE_W:0]   jump_raw;
    logic signed [ANGLE_W:0]   jump;
    logic [ANGLE_W:0]          mag;
    logic                      too_far;

    // The change is formed at 33 bits; wrapping keeps the low TURN_W (16) bits, sign-extended.
    always_comb
    begin
        jump_raw = {req.sample_angle[ANGLE_W-1], req.sample_angle}
                 - {held_angle_reg[ANGLE_W-1], held_angle_reg};
        if (cfg.wrap_mode)
        begin
            jump = {{(ANGLE_W+1-TURN_W){jump_raw[TURN_W-1]}}, jump_raw[TURN_W-1:0]};
        end
        else
        begin
            jump = jump_raw;
        end
        mag = jump[ANGLE_W] ? (~jump + 1'b1) : jump;
        too_far = mag > {2'b00, cfg.jump_limit};
    end

    always_comb
    begin
        has_value_next = has_value_reg;
        held_angle_next = held_angle_reg;
        last_token_next = last_token_reg;
        reject_count_next = reject_count_reg;
        rsp.out_angle = '0;
        rsp.status = ST_FAILED;

        if (req.opcode == OP_RESET)
        begin
            has_value_next = 1'b0;
            last_token_next = req.frame_token;
            rsp.status = ST_RESET;
        end
        else if (cfg.jump_limit == '0)
        begin
            rsp.status = ST_FAILED;
        end
        else if (has_value_reg && (last_token_reg == req.frame_token))
        begin
            rsp.out_angle = held_angle_reg;
            rsp.status = ST_DUPLICATE;
        end
        else
        begin
            last_token_next = req.frame_token;
            if (!req.sample_valid)
            begin
                reject_count_next = reject_count_reg + 1'b1;
                if (has_value_reg)
                begin
                    rsp.out_angle = held_angle_reg;
                    rsp.status = ST_REJECTED;
                end
                else
                begin
                    rsp.status = ST_FAILED;
                end
            end
            else if (!has_value_reg)
            begin
                has_value_next = 1'b1;
                held_angle_next = req.sample_angle;
                rsp.out_angle = req.sample_angle;
                rsp.status = ST_INIT;
            end
            else if (too_far)
            begin
                reject_count_next = reject_count_reg + 1'b1;
                rsp.out_angle = held_angle_reg;
                rsp.status = ST_REJECTED;
            end
            else
            begin
                held_angle_next = req.sample_angle;
                rsp.out_angle = req.sample_angle;
                rsp.status = ST_ACCEPTED;
            end
        end
        rsp.reject_total = reject_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_value_reg <= 1'b0;
            held_angle_reg <= '0;
            last_token_reg <= '0;
            reject_count_reg <= '0;
        end
        else if (fire)
        begin
            has_value_reg <= has_value_next;
            held_angle_reg <= held_angle_next;
            last_token_reg <= last_token_next;
            reject_count_reg <= reject_count_next;
        end
    end

endmodule

// ===== design/angle_jump_rejection_filter_core.sv =====
// Top level of the angle jump rejection filter: request register, filter and response register.
//
//   Channel    Signals                          Direction  Content
//   request    req_valid, req_stall, req        in         one sample or filter reset
//   response   rsp_valid, rsp_stall, rsp        out        one filtered angle and status
//   config     cfg_write, cfg_index, cfg_data   in         jump limit and wrap mode
//
// Each transaction passes through the request register and then lands in the
// response register, from which its response is offered until it is taken.
// One request is accepted every cycle while req_stall is low; the filter
// state updates as a request leaves the request register, so consecutive
// requests see each other's effect.
// Reset restores the register defaults and clears the filter state at once.
// A stalled response holds the pipeline, and the request channel stalls only when both
// registers are occupied and the response is stalled.
module angle_jump_rejection_filter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  ajrf_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output ajrf_pkg::rsp_t                   rsp,
    input  logic                             cfg_write,
    input  logic [ajrf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ajrf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ajrf_pkg::*;

    cfg_t cfg;
    req_t req_reg;
    logic req_valid_reg;
    logic req_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic accept;
    logic advance;

    ajrf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ajrf_filter u_filter (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (req_reg),
        .cfg   (cfg),
        .rsp   (rsp_next)
    );

    assign advance = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !advance;
    assign accept = req_valid && !req_stall;
    assign req_valid_next = accept || (req_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

// ===== design/ajrf_checker.sv =====
// Port-level checks of the angle jump rejection filter and their binding to the top level.
module ajrf_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input ajrf_pkg::rsp_t rsp
);
    import ajrf_pkg::*;

    // A stalled response stays offered and unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // Every accepted request is followed by a response on offer after the request register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |-> ##2 rsp_valid)
        else $error("response missing two cycles after request");

    // Reset and failed responses carry a zero angle.
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_RESET || rsp.status == ST_FAILED)
            |-> rsp.out_angle == '0)
        else $error("non-zero angle on reset or failed response");

    // A duplicate never moves the reject count between back-to-back responses.
    a_dup_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall ##1 rsp_valid && rsp.status == ST_DUPLICATE
            |-> rsp.reject_total == $past(rsp.reject_total))
        else $error("reject count changed on a duplicate");

endmodule

bind angle_jump_rejection_filter_core ajrf_checker u_ajrf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
